// ----- rtl/tpt_pkg.sv -----
// shared types and constants for the tlb page table translator
package tpt_pkg;

  localparam int ADDR_W  = 16;
  localparam int TAG_W   = 8;
  localparam int FRAME_W = 8;
  localparam int STAMP_W = 32;
  localparam int FREE_W  = 9;

  localparam logic [FREE_W-1:0]  FREE_MAX  = 9'd511;
  localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [ADDR_W-1:0] virtual_address;
  } va_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              page_fault;
  } pa_beat_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] tick;
    logic               touch;
  } cell_cmd_t;

  typedef struct packed {
    logic               vld;
    logic [STAMP_W-1:0] stamp;
  } scan_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [FRAME_W-1:0] frame;
  } pt_req_t;

  typedef struct packed {
    logic               mapped;
    logic [FRAME_W-1:0] frame;
  } pt_rsp_t;

endpackage

// ----- rtl/tpt_if.sv -----
// valid/ready channels for virtual and physical address beats
interface tpt_va_if import tpt_pkg::*; ();
  logic     valid;
  logic     ready;
  va_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpt_pa_if import tpt_pkg::*; ();
  logic     valid;
  logic     ready;
  pa_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/tpt_addr_split.sv -----
// four stage split of a virtual address into page and offset by constant division
module tpt_addr_split import tpt_pkg::*; #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [ADDR_W-1:0]             va_i,
  output logic                          vld_o,
  output logic [$clog2(PAGE_COUNT)-1:0] page_o,
  output logic [$clog2(PAGE_BYTES)-1:0] off_o
);

  localparam int PAGE_W   = $clog2(PAGE_COUNT);
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int ADDR_MAX = (1 << ADDR_W) - 1;
  localparam int Q_W      = $clog2(ADDR_MAX / PAGE_BYTES + 1);
  localparam longint unsigned RECIP_B = (64'd1 << 32) / PAGE_BYTES;
  localparam longint unsigned RECIP_P = (64'd1 << 32) / PAGE_COUNT;
  localparam int RB_W = $clog2(RECIP_B + 1);
  localparam int RP_W = $clog2(RECIP_P + 1);
  localparam int P1_W = ADDR_W + RB_W;
  localparam int P2_W = Q_W + RP_W;
  localparam int R_W  = ADDR_W + 1;
  localparam int M_W  = Q_W + PAGE_W + 1;

  logic [3:0]          vld_q;
  logic [ADDR_W-1:0]   s1_va_q;
  logic [Q_W-1:0]      s1_q_q;
  logic [Q_W-1:0]      s2_q_q;
  logic [OFF_W-1:0]    s2_off_q;
  logic [Q_W-1:0]      s3_p_q;
  logic [Q_W-1:0]      s3_q_q;
  logic [OFF_W-1:0]    s3_off_q;
  logic [PAGE_W-1:0]   s4_page_q;
  logic [OFF_W-1:0]    s4_off_q;

  logic [P1_W-1:0]     prod1;
  logic [P2_W-1:0]     prod2;
  logic [R_W-1:0]      rem1;
  logic [Q_W-1:0]      q1_d;
  logic [OFF_W-1:0]    off_d;
  logic [M_W-1:0]      rem2;
  logic [PAGE_W-1:0]   page_d;

  assign prod1 = P1_W'(va_i) * P1_W'(RECIP_B);
  assign prod2 = P2_W'(s2_q_q) * P2_W'(RECIP_P);

  always_comb begin
    rem1 = R_W'(s1_va_q) - R_W'(s1_q_q) * R_W'(PAGE_BYTES);
    q1_d = s1_q_q;
    off_d = OFF_W'(rem1);
    if (rem1 >= R_W'(PAGE_BYTES)) begin
      q1_d = s1_q_q + Q_W'(1);
      off_d = OFF_W'(rem1 - R_W'(PAGE_BYTES));
    end
  end

  always_comb begin
    rem2 = M_W'(s3_q_q) - M_W'(s3_p_q) * M_W'(PAGE_COUNT);
    if (rem2 >= M_W'(PAGE_COUNT)) begin
      rem2 = rem2 - M_W'(PAGE_COUNT);
    end
    page_d = PAGE_W'(rem2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      s1_va_q <= va_i;
      s1_q_q  <= Q_W'(prod1 >> 32);
    end
    if (vld_q[0]) begin
      s2_q_q   <= q1_d;
      s2_off_q <= off_d;
    end
    if (vld_q[1]) begin
      s3_p_q   <= Q_W'(prod2 >> 32);
      s3_q_q   <= s2_q_q;
      s3_off_q <= s2_off_q;
    end
    if (vld_q[2]) begin
      s4_page_q <= page_d;
      s4_off_q  <= s3_off_q;
    end
  end

  assign vld_o  = vld_q[3];
  assign page_o = s4_page_q;
  assign off_o  = s4_off_q;

endmodule

// ----- rtl/tpt_tlb_cell.sv -----
// one tlb entry with tag compare, stamp update and a link of the victim scan chain
module tpt_tlb_cell import tpt_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic               fill_i,
  input  scan_t              scan_i,
  input  logic [IDX_W-1:0]   scan_idx_i,
  output scan_t              scan_o,
  output logic [IDX_W-1:0]   scan_idx_o,
  output logic               hit_o,
  output logic [FRAME_W-1:0] frame_o
);

  logic               valid_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [TAG_W-1:0]   tag_q;
  logic [FRAME_W-1:0] frame_q;
  logic               scan_vld_q;
  logic [STAMP_W-1:0] scan_stamp_q;
  logic [IDX_W-1:0]   scan_idx_q;

  assign hit_o   = valid_q && (tag_q == cmd_i.tag);
  assign frame_o = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      stamp_q    <= '0;
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= scan_i.vld;
      if (fill_i) begin
        valid_q <= 1'b1;
        stamp_q <= cmd_i.tick;
      end else if (cmd_i.touch && hit_o) begin
        stamp_q <= cmd_i.tick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i) begin
      tag_q   <= cmd_i.tag;
      frame_q <= cmd_i.frame;
    end
    // strict compare keeps the lower index on a tie
    if (scan_i.vld) begin
      if (stamp_q < scan_i.stamp) begin
        scan_stamp_q <= stamp_q;
        scan_idx_q   <= IDX_W'(IDX);
      end else begin
        scan_stamp_q <= scan_i.stamp;
        scan_idx_q   <= scan_idx_i;
      end
    end
  end

  assign scan_o     = '{vld: scan_vld_q, stamp: scan_stamp_q};
  assign scan_idx_o = scan_idx_q;

endmodule

// ----- rtl/tpt_page_table.sv -----
// page table memory with mapped flag and a clearing pass after reset
module tpt_page_table import tpt_pkg::*; #(
  parameter int PAGE_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pt_req_t                       req_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] addr_i,
  output pt_rsp_t                       rsp_o,
  output logic                          busy_o
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);

  pt_rsp_t           mem_q [PAGE_COUNT];
  pt_rsp_t           rdata_q;
  logic              busy_q;
  logic [PAGE_W-1:0] clr_q;

  logic              wr_en;
  logic [PAGE_W-1:0] wr_addr;
  pt_rsp_t           wr_data;

  always_comb begin
    wr_en   = busy_q || req_i.wr;
    wr_addr = busy_q ? clr_q : addr_i;
    wr_data = '0;
    if (!busy_q) begin
      wr_data = '{mapped: 1'b1, frame: req_i.frame};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == PAGE_W'(PAGE_COUNT - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + PAGE_W'(1);
      end
    end
  end

  assign rsp_o  = rdata_q;
  assign busy_o = busy_q;

endmodule

// ----- rtl/tlb_page_table_translator.sv -----
// top level: tlb backed demand paging address translator
//
// usage
//   va_i carries one virtual address per beat, pa_o returns one result beat
//   per address: physical address, tlb hit flag and page fault flag.
//   the block works on one address at a time; va_i.ready is high only while
//   the translator is idle, also when a finished result still waits on pa_o.
// hit and miss path
//   tlb hit: the result is set by the four stage page/offset split (constant
//   division) plus the parallel tag compare of all cells.
//   tlb miss: the victim scan then crosses the cell chain one cell per cycle
//   while the page table read completes.
// reset
//   all tlb entries invalid, stamps, tick and free frame counter zero. the
//   page table then runs a clearing pass over all PAGE_COUNT entries, during
//   which va_i.ready stays low.
// stall
//   a result waiting on pa_o holds; the next address is accepted but its
//   result is held back until the waiting beat is taken.
module tlb_page_table_translator import tpt_pkg::*; #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_BYTES  = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tpt_va_if.sink   va_i,
  tpt_pa_if.source pa_o
);

  localparam int IDX_W  = $clog2(TLB_ENTRIES);
  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int PA_W   = FRAME_W + OFF_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [STAMP_W-1:0] tick_q;
  logic [FREE_W-1:0]  nff_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic               hit_q;
  logic               fault_q;
  logic               out_vld_q;
  pa_beat_t           out_q;

  logic               in_acc;
  logic               split_vld;
  logic [PAGE_W-1:0]  page;
  logic [OFF_W-1:0]   off;
  logic               pt_busy;
  pt_req_t            pt_req;
  pt_rsp_t            pt_rsp;

  cell_cmd_t              cmd;
  logic [TLB_ENTRIES-1:0] hit_vec;
  logic [TLB_ENTRIES-1:0] fill_vec;
  logic [FRAME_W-1:0]     frame_arr [TLB_ENTRIES];
  scan_t                  scan [TLB_ENTRIES+1];
  logic [IDX_W-1:0]       scan_idx [TLB_ENTRIES+1];

  logic               hit_any;
  logic [FRAME_W-1:0] hit_frame;
  logic               lookup;
  logic               miss;
  logic               scan_done;
  logic               fill_go;
  logic [FRAME_W-1:0] frame_sel;
  logic [PA_W-1:0]    pa_full;
  logic               out_load;

  assign in_acc     = va_i.valid && va_i.ready;
  assign va_i.ready = (state_q == ST_IDLE) && !pt_busy;

  tpt_addr_split #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_acc),
    .va_i   (va_i.payload.virtual_address),
    .vld_o  (split_vld),
    .page_o (page),
    .off_o  (off)
  );

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | (frame_arr[i] & {FRAME_W{hit_vec[i]}});
    end
  end

  assign hit_any   = |hit_vec;
  assign lookup    = (state_q == ST_SPLIT) && split_vld;
  assign miss      = lookup && !hit_any;
  assign scan_done = scan[TLB_ENTRIES].vld;
  assign fill_go   = (state_q == ST_SCAN) && scan_done;
  assign frame_sel = pt_rsp.mapped ? pt_rsp.frame : nff_q[FRAME_W-1:0];
  assign out_load  = (state_q == ST_RESP) && (!out_vld_q || pa_o.ready);

  assign cmd = '{tag: TAG_W'(page), frame: frame_sel, tick: tick_q, touch: lookup};

  // scan enters at the first cell holding the highest stamp and index zero
  assign scan[0]     = '{vld: miss, stamp: STAMP_MAX};
  assign scan_idx[0] = '0;

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    assign fill_vec[g] = fill_go && (scan_idx[TLB_ENTRIES] == IDX_W'(g));

    tpt_tlb_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .fill_i     (fill_vec[g]),
      .scan_i     (scan[g]),
      .scan_idx_i (scan_idx[g]),
      .scan_o     (scan[g+1]),
      .scan_idx_o (scan_idx[g+1]),
      .hit_o      (hit_vec[g]),
      .frame_o    (frame_arr[g])
    );
  end

  assign pt_req = '{rd: miss, wr: fill_go && !pt_rsp.mapped, frame: nff_q[FRAME_W-1:0]};

  tpt_page_table #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_pt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pt_req),
    .addr_i (page),
    .rsp_o  (pt_rsp),
    .busy_o (pt_busy)
  );

  assign pa_full = PA_W'(res_frame_q) * PA_W'(PAGE_BYTES) + PA_W'(off);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      nff_q       <= '0;
      res_frame_q <= '0;
      hit_q       <= 1'b0;
      fault_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_q     <= '{physical_address: ADDR_W'(pa_full),
                       tlb_hit: hit_q,
                       page_fault: fault_q};
      end else if (pa_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (tick_q != STAMP_MAX) begin
              tick_q <= tick_q + STAMP_W'(1);
            end
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (split_vld) begin
            hit_q <= hit_any;
            if (hit_any) begin
              res_frame_q <= hit_frame;
              fault_q     <= 1'b0;
              state_q     <= ST_RESP;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            res_frame_q <= frame_sel;
            fault_q     <= !pt_rsp.mapped;
            if (!pt_rsp.mapped && (nff_q != FREE_MAX)) begin
              nff_q <= nff_q + FREE_W'(1);
            end
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign pa_o.valid   = out_vld_q;
  assign pa_o.payload = out_q;

endmodule

// ----- rtl/tpt_checker.sv -----
// port level checks for the translator and their binding to the top level
module tpt_checker import tpt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     va_valid_i,
  input logic     va_ready_i,
  input logic     pa_valid_i,
  input logic     pa_ready_i,
  input pa_beat_t pa_i
);

  a_pa_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_valid_i && !pa_ready_i |=> pa_valid_i)
    else $error("result beat dropped while stalled");

  a_pa_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_valid_i && !pa_ready_i |=> $stable(pa_i))
    else $error("result beat changed while stalled");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_valid_i |-> !(pa_i.tlb_hit && pa_i.page_fault))
    else $error("tlb hit reported together with page fault");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_valid_i && va_ready_i |=> !va_ready_i)
    else $error("second address taken while one is in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_valid_i && va_ready_i |=> !$rose(pa_valid_i))
    else $error("result appeared right after an address beat");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .va_valid_i (va_i.valid),
  .va_ready_i (va_i.ready),
  .pa_valid_i (pa_o.valid),
  .pa_ready_i (pa_o.ready),
  .pa_i       (pa_o.payload)
);
